// ----- design/tttw_pkg.sv -----
// Shared types and constants for the thermal threshold window tracker.
// Holds code/temperature widths, conversion constants, register indexes and
// the command and result structs; no dependencies.
package tttw_pkg;

	localparam int CODE_BITS = 8;
	localparam int TEMP_W    = 19;
	localparam int NUM_W     = 38;
	localparam int DEN_W     = 20;
	localparam int SCL_W     = 21;
	localparam int CNT_W     = $clog2(NUM_W);
	localparam int STEP_W    = 7;
	localparam int IDX_W     = 3;
	localparam int CFG_W     = 19;

	localparam logic [NUM_W-1:0]  K_SLOPE   = 38'd13150000;
	localparam logic [NUM_W-1:0]  K_OFFSET  = 38'd251210000000;
	localparam logic [SCL_W-1:0]  K_ONE     = 21'd1000000;
	localparam logic [SCL_W-1:0]  K_DEN     = 21'd1461;
	localparam logic [TEMP_W:0]   K_KELVIN  = 20'd273000;
	localparam logic [NUM_W-1:0]  Q_MAX     = 38'd535143;
	localparam logic [NUM_W-1:0]  Q_MIN     = 38'd10856;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 19'sd262143;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -19'sd262144;
	localparam logic signed [TEMP_W-1:0] RESET_TEMP = 19'sd40000;
	localparam logic [CODE_BITS-1:0] RESET_CODE = CODE_BITS'(131);
	localparam logic [STEP_W-1:0] RESET_STEP = 7'd8;

	localparam logic [IDX_W-1:0] REG_WINDOW_STEP = 3'd0;
	localparam logic [IDX_W-1:0] REG_LOW_EN      = 3'd1;
	localparam logic [IDX_W-1:0] REG_LOW_TRIP    = 3'd2;
	localparam logic [IDX_W-1:0] REG_HIGH_EN     = 3'd3;
	localparam logic [IDX_W-1:0] REG_HIGH_TRIP   = 3'd4;

	typedef struct packed {
		logic [STEP_W-1:0]        window_step;
		logic                     low_en;
		logic signed [TEMP_W-1:0] low_trip;
		logic                     high_en;
		logic signed [TEMP_W-1:0] high_trip;
	} cfg_t;

	typedef struct packed {
		logic ld;
		logic upd;
		logic prep;
		logic sel;
		logic step;
		logic save;
		logic fin;
	} dp_cmd_t;

	typedef struct packed {
		logic                     accepted;
		logic [7:0]               low_code;
		logic [7:0]               high_code;
		logic signed [TEMP_W-1:0] temperature;
		logic                     notify;
		logic                     notify_kind;
	} result_t;

endpackage

// ----- design/tttw_ctrl.sv -----
// Sequencer for the threshold window tracker: accept, update, two serial
// conversions, average, then hand the word to the output register.
// Depends on tttw_pkg.
module tttw_ctrl
	import tttw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_ok,
	input  logic    out_free,
	output logic    in_ready,
	output logic    emit,
	output dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_SAVE = 3'd4;
	localparam logic [2:0] ST_AVG  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             sel_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = sel_q;
		emit     = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld  = 1'b1;
					state_d = in_ok ? ST_UPD : ST_EMIT;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1))
					state_d = ST_SAVE;
			end
			ST_SAVE: begin
				cmd.save = 1'b1;
				state_d  = sel_q ? ST_AVG : ST_PREP;
			end
			ST_AVG: begin
				cmd.fin = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_UPD)
				sel_q <= 1'b0;
			else if (state_q == ST_SAVE)
				sel_q <= 1'b1;
			if (state_q == ST_PREP)
				cnt_q <= '0;
			else if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_W'(NUM_W - 1)) |=> state_q == ST_SAVE)
		else $error("divider did not finish after full iteration count");

	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && !in_ok) |=> state_q == ST_EMIT)
		else $error("unconfirmed word did not go straight to output");

	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SAVE && !sel_q) |=> (state_q == ST_PREP && sel_q))
		else $error("high code conversion not started after low");

endmodule

// ----- design/tttw_dp.sv -----
// Datapath for the threshold window tracker: window codes, estimate,
// code-to-millidegree conversion with a serial restoring divider, trip check.
// Depends on tttw_pkg.
module tttw_dp
	import tttw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  dp_cmd_t cmd,
	input  cfg_t    cfg,
	input  logic    in_side,
	input  logic    in_ok,
	output result_t res
);

	logic [CODE_BITS-1:0]     low_code_q, high_code_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic                     side_q, ok_q, notify_q, kind_q;
	logic [NUM_W-1:0]         num_q;
	logic [DEN_W-1:0]         den_q;
	logic [DEN_W:0]           rem_q;
	logic                     sat_q;
	logic signed [TEMP_W-1:0] lo_t_q, hi_t_q;

	logic [CODE_BITS-1:0]     code;
	logic [SCL_W-1:0]         scaled;
	logic [DEN_W-1:0]         den;
	logic [NUM_W-1:0]         num;
	logic [DEN_W:0]           trial;
	logic [DEN_W+1:0]         diff;
	logic                     ge;
	logic [TEMP_W:0]          q_off;
	logic signed [TEMP_W-1:0] conv;
	logic signed [TEMP_W:0]   sum, adj;
	logic signed [TEMP_W-1:0] avg;
	logic                     hit;

	always_comb begin
		code   = cmd.sel ? high_code_q : low_code_q;
		scaled = SCL_W'(code) * K_DEN;
		den    = DEN_W'(K_ONE - scaled);
		num    = NUM_W'(code) * K_SLOPE + K_OFFSET + NUM_W'(den >> 1);

		trial = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		ge    = !diff[DEN_W+1];

		q_off = num_q[TEMP_W:0] - K_KELVIN;
		if (sat_q || num_q > Q_MAX)
			conv = TEMP_MAX;
		else if (num_q < Q_MIN)
			conv = TEMP_MIN;
		else
			conv = TEMP_W'(q_off);

		sum = {lo_t_q[TEMP_W-1], lo_t_q} + {hi_t_q[TEMP_W-1], hi_t_q};
		adj = sum + (TEMP_W + 1)'(sum[TEMP_W]);
		avg = adj[TEMP_W:1];
		if (side_q)
			hit = cfg.high_en && (avg > cfg.high_trip);
		else
			hit = cfg.low_en && (avg < cfg.low_trip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_code_q  <= RESET_CODE;
			high_code_q <= RESET_CODE;
			temp_q      <= RESET_TEMP;
			notify_q    <= 1'b0;
			kind_q      <= 1'b0;
		end else begin
			if (cmd.ld) begin
				notify_q <= 1'b0;
				kind_q   <= 1'b0;
			end
			if (cmd.upd) begin
				if (side_q) begin
					low_code_q  <= CODE_BITS'(32'(high_code_q) - 32'(cfg.window_step));
					high_code_q <= CODE_BITS'(32'(high_code_q) + 32'(cfg.window_step));
				end else begin
					high_code_q <= CODE_BITS'(32'(low_code_q) + 32'(cfg.window_step));
					low_code_q  <= CODE_BITS'(32'(low_code_q) - 32'(cfg.window_step));
				end
			end
			if (cmd.fin) begin
				temp_q   <= avg;
				notify_q <= hit;
				kind_q   <= hit & side_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			side_q <= in_side;
			ok_q   <= in_ok;
		end
		if (cmd.prep) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			sat_q <= (scaled >= K_ONE);
		end else if (cmd.step) begin
			rem_q <= ge ? diff[DEN_W:0] : trial;
			num_q <= {num_q[NUM_W-2:0], ge};
		end
		if (cmd.save) begin
			if (cmd.sel)
				hi_t_q <= conv;
			else
				lo_t_q <= conv;
		end
	end

	always_comb begin
		res.accepted    = ok_q;
		res.low_code    = 8'(low_code_q);
		res.high_code   = 8'(high_code_q);
		res.temperature = temp_q;
		res.notify      = notify_q;
		res.notify_kind = kind_q;
	end

endmodule

// ----- design/thermal_threshold_window_tracker.sv -----
// Top level of the thermal threshold window tracker: configuration registers,
// output register and the controller/datapath pair.
// Depends on tttw_pkg, tttw_ctrl, tttw_dp.
//
//   channel  | dir | tdata                                   | tuser
//   ---------+-----+-----------------------------------------+----------------
//   s_*      | in  | [0] confirmed                           | which_threshold
//   m_*      | out | [0] accepted [8:1] low_code [16:9]      | notify_kind
//            |     | high_code [35:17] temperature [36] notify|
//   cfg_*    | in  | index 0..4, data up to 19 bits          | -
//
// A confirmed word passes through update, two 38-step restoring divisions (one
// per window code, each with its setup and save) and average, then waits for
// a free output register; the block takes no new word until it is emitted.
// An unconfirmed word skips conversion and goes straight to the output stage.
// One word is in flight at a time; s_tready is high only while idle.
// The output register holds a finished word while m_tready is low; the next
// word may be accepted meanwhile. Reset restores codes 131 and 40000 mC.
module thermal_threshold_window_tracker
	import tttw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [0] confirmed
	input  logic             s_tuser,   // [0] which_threshold
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,   // [0] accepted, [8:1] low_code, [16:9] high_code,
	                                    // [35:17] temperature, [36] notify
	output logic             m_tuser,   // [0] notify_kind
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	result_t res;
	logic    emit;
	logic    out_free;
	logic    m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic    m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_step <= RESET_STEP;
			cfg_q.low_en      <= 1'b0;
			cfg_q.low_trip    <= '0;
			cfg_q.high_en     <= 1'b0;
			cfg_q.high_trip   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_STEP: cfg_q.window_step <= cfg_wdata[STEP_W-1:0];
				REG_LOW_EN:      cfg_q.low_en      <= cfg_wdata[0];
				REG_LOW_TRIP:    cfg_q.low_trip    <= cfg_wdata[TEMP_W-1:0];
				REG_HIGH_EN:     cfg_q.high_en     <= cfg_wdata[0];
				REG_HIGH_TRIP:   cfg_q.high_trip   <= cfg_wdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	tttw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ok    (s_tdata[0]),
		.out_free (out_free),
		.in_ready (s_tready),
		.emit     (emit),
		.cmd      (cmd)
	);

	tttw_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cfg     (cfg_q),
		.in_side (s_tuser),
		.in_ok   (s_tdata[0]),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (emit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {3'b000, res.notify, res.temperature, res.high_code,
				res.low_code, res.accepted};
			m_tuser_q <= res.notify_kind;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- bench/thermal_threshold_window_tracker_tb.sv -----
// Self-checking bench for the thermal threshold window tracker: a directed event table, then
// random event runs under several trip and step settings, all scored against a window predictor.
// Depends on tttw_pkg and the thermal_threshold_window_tracker RTL.
module thermal_threshold_window_tracker_tb
	import tttw_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic SIDE_LOW  = 1'b0;
	localparam logic SIDE_HIGH = 1'b1;
	localparam int   STALL_LIMIT = 3000;
	localparam int   HOLD_CYCLES = 400;
	localparam int   PHASES      = 8;
	localparam int   PHASE_WORDS = 75;
	localparam int   TAIL_CYCLES = 200;

	typedef enum logic {ROW_CFG, ROW_EVENT} row_kind_e;

	typedef struct {
		row_kind_e        kind;
		logic [IDX_W-1:0] index;
		logic [CFG_W-1:0] value;
		logic             which;
		logic             conf;
		bit               typed;
		result_t          want;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [39:0]      m_tdata;
	logic             m_tuser;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	logic [STEP_W-1:0]        win_step;
	logic                     low_en, high_en;
	logic signed [TEMP_W-1:0] low_trip, high_trip;
	logic [CODE_BITS-1:0]     low_code, high_code;
	logic signed [TEMP_W-1:0] temp_est;

	result_t pending_words[$];
	row_t    event_table[$];
	int      faults = 0;
	int      words_out = 0;
	int      idle_cycles = 0;
	int      hold_left = 0;
	bit      hold_done = 1'b0;

	thermal_threshold_window_tracker u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic signed [TEMP_W-1:0] code_to_millideg(input logic [CODE_BITS-1:0] c);
		longint unsigned scaled, num, den, q;
		longint t;
		scaled = 64'(c) * 64'd1461;
		if (scaled >= 64'd1000000)
			return TEMP_MAX;
		den = 64'd1000000 - scaled;
		num = 64'(c) * 64'd13150000 + 64'd251210000000;
		q = (num + den / 2) / den;
		if (q > 64'd273000 + 64'd262143)
			return TEMP_MAX;
		t = longint'(q) - 273000;
		if (t < -262144)
			t = -262144;
		return TEMP_W'(t);
	endfunction

	function automatic result_t advance_window(input logic which, input logic conf);
		result_t r;
		longint lo_t, hi_t, avg;
		r = '0;
		if (conf) begin
			if (which == SIDE_LOW) begin
				high_code = low_code + CODE_BITS'(win_step);
				low_code = low_code - CODE_BITS'(win_step);
			end else begin
				low_code = high_code - CODE_BITS'(win_step);
				high_code = high_code + CODE_BITS'(win_step);
			end
			lo_t = longint'(code_to_millideg(low_code));
			hi_t = longint'(code_to_millideg(high_code));
			avg = (lo_t + hi_t) / 2;
			temp_est = TEMP_W'(avg);
			if (which == SIDE_LOW)
				r.notify = low_en && (avg < longint'(low_trip));
			else
				r.notify = high_en && (avg > longint'(high_trip));
			r.notify_kind = r.notify ? which : 1'b0;
		end
		r.accepted = conf;
		r.low_code = 8'(low_code);
		r.high_code = 8'(high_code);
		r.temperature = temp_est;
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] pick_trip();
		case ($urandom_range(7))
		0: return CFG_W'(-40000);
		1: return CFG_W'(200000);
		2: return CFG_W'($urandom);
		default: return CFG_W'(int'($urandom_range(154502)) - 21790);
		endcase
	endfunction

	function automatic void add_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		row_t r;
		r = '{kind: ROW_CFG, index: idx, value: val, which: 1'b0, conf: 1'b0, typed: 1'b0,
			want: '0};
		event_table.push_back(r);
	endfunction

	function automatic void add_event(input logic which, input logic conf, input bit typed,
		input result_t want);
		row_t r;
		r = '{kind: ROW_EVENT, index: '0, value: '0, which: which, conf: conf, typed: typed,
			want: want};
		event_table.push_back(r);
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
		REG_WINDOW_STEP: win_step = val[STEP_W-1:0];
		REG_LOW_EN:      low_en = val[0];
		REG_LOW_TRIP:    low_trip = val;
		REG_HIGH_EN:     high_en = val[0];
		REG_HIGH_TRIP:   high_trip = val;
		default: ;
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic send_event(input logic which, input logic conf, input bit typed,
		input result_t want, input bit calm);
		result_t r;
		while (!calm && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, conf};
		s_tuser <= which;
		do @(posedge clk); while (!s_tready);
		r = advance_window(which, conf);
		pending_words.push_back(typed ? want : r);
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && words_out >= 350) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (words_out >= 150 && words_out < 250)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) >= 18);
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.accepted = m_tdata[0];
				got.low_code = m_tdata[8:1];
				got.high_code = m_tdata[16:9];
				got.temperature = m_tdata[35:17];
				got.notify = m_tdata[36];
				got.notify_kind = m_tuser;
				words_out <= words_out + 1;
				if (pending_words.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("unexpected word: acc=%0b lo=%0d hi=%0d t=%0d n=%0b k=%0b",
							got.accepted, got.low_code, got.high_code, got.temperature,
							got.notify, got.notify_kind);
				end else begin
					want = pending_words.pop_front();
					if (got !== want) begin
						faults++;
						if (faults <= 10)
							$display("mismatch: exp acc=%0b lo=%0d hi=%0d t=%0d n=%0b k=%0b",
								want.accepted, want.low_code, want.high_code,
								want.temperature, want.notify, want.notify_kind,
								" got acc=%0b lo=%0d hi=%0d t=%0d n=%0b k=%0b",
								got.accepted, got.low_code, got.high_code, got.temperature,
								got.notify, got.notify_kind);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("thermal_threshold_window_tracker_tb: errors");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		result_t at_reset;
		int n;
		logic [CFG_W-1:0] step_val;

		win_step = RESET_STEP;
		low_en = 1'b0;
		high_en = 1'b0;
		low_trip = '0;
		high_trip = '0;
		low_code = RESET_CODE;
		high_code = RESET_CODE;
		temp_est = RESET_TEMP;

		at_reset = '0;
		at_reset.low_code = 8'(RESET_CODE);
		at_reset.high_code = 8'(RESET_CODE);
		at_reset.temperature = RESET_TEMP;

		add_event(SIDE_LOW, 1'b0, 1'b1, at_reset);
		add_event(SIDE_HIGH, 1'b0, 1'b1, at_reset);
		add_event(SIDE_LOW, 1'b1, 1'b0, '0);
		add_event(SIDE_HIGH, 1'b1, 1'b0, '0);
		add_cfg(REG_WINDOW_STEP, CFG_W'(0));
		add_event(SIDE_LOW, 1'b1, 1'b0, '0);
		add_event(SIDE_HIGH, 1'b1, 1'b0, '0);
		add_cfg(REG_WINDOW_STEP, CFG_W'(127));
		add_cfg(REG_LOW_EN, CFG_W'(1));
		add_cfg(REG_LOW_TRIP, CFG_W'(200000));
		add_cfg(REG_HIGH_EN, CFG_W'(1));
		add_cfg(REG_HIGH_TRIP, CFG_W'(-40000));
		add_event(SIDE_LOW, 1'b1, 1'b0, '0);
		add_event(SIDE_HIGH, 1'b1, 1'b0, '0);
		add_event(SIDE_HIGH, 1'b0, 1'b0, '0);
		add_event(SIDE_LOW, 1'b1, 1'b0, '0);
		add_cfg(REG_LOW_TRIP, CFG_W'(-40000));
		add_cfg(REG_HIGH_TRIP, CFG_W'(200000));
		add_event(SIDE_LOW, 1'b1, 1'b0, '0);
		add_event(SIDE_HIGH, 1'b1, 1'b0, '0);
		add_cfg(REG_LOW_TRIP, CFG_W'(-262144));
		add_cfg(REG_HIGH_TRIP, CFG_W'(262143));
		add_event(SIDE_LOW, 1'b1, 1'b0, '0);
		add_event(SIDE_HIGH, 1'b1, 1'b0, '0);
		add_cfg(REG_WINDOW_STEP, CFG_W'(1));
		repeat (3) add_event(SIDE_LOW, 1'b1, 1'b0, '0);
		repeat (3) add_event(SIDE_HIGH, 1'b1, 1'b0, '0);
		add_cfg(REG_LOW_EN, CFG_W'(0));
		add_cfg(REG_LOW_TRIP, CFG_W'(262143));
		add_cfg(REG_HIGH_EN, CFG_W'(0));
		add_cfg(REG_HIGH_TRIP, CFG_W'(-262144));
		add_event(SIDE_LOW, 1'b1, 1'b0, '0);
		add_event(SIDE_HIGH, 1'b1, 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (event_table[i]) begin
			if (event_table[i].kind == ROW_CFG) begin
				if (i == 0 || event_table[i-1].kind == ROW_EVENT)
					drain();
				write_reg(event_table[i].index, event_table[i].value);
				if (i + 1 == event_table.size() || event_table[i+1].kind != ROW_CFG)
					cfg_we <= 1'b0;
			end else begin
				send_event(event_table[i].which, event_table[i].conf, event_table[i].typed,
					event_table[i].want, 1'b0);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case ($urandom_range(7))
			0: step_val = CFG_W'(0);
			1: step_val = CFG_W'(127);
			default: step_val = CFG_W'($urandom_range(127));
			endcase
			write_reg(REG_WINDOW_STEP, step_val);
			write_reg(REG_LOW_EN, CFG_W'($urandom_range(99) < 70));
			write_reg(REG_LOW_TRIP, pick_trip());
			write_reg(REG_HIGH_EN, CFG_W'($urandom_range(99) < 70));
			write_reg(REG_HIGH_TRIP, pick_trip());
			cfg_we <= 1'b0;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				n = ph * PHASE_WORDS + k;
				send_event(1'($urandom_range(1)), 1'($urandom_range(99) < 80), 1'b0, '0,
					n >= 150 && n < 250);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("thermal_threshold_window_tracker_tb: clean");
		else
			$display("thermal_threshold_window_tracker_tb: errors");
		$finish;
	end

endmodule
